// ===== rtl/core/sha256_pkg.sv =====
// SHA-256 hasher shared types, constants and a rotate function.
package sha256_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROUND = 6'b000010,
    ST_FOLD  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_CLEAR = 6'b100000
  } state_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_byte;
    logic       len_inc;
    logic       start;
    logic       round;
    logic       fold;
    logic       reinit;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [5:0]  rnd;
    logic [63:0] bit_len;
  } status_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_dp.sv =====
// SHA-256 datapath: block store, message schedule, round unit and chain words.
module sha256_dp (
  input  logic                clk,
  input  sha256_pkg::cmd_t    cmd,
  input  logic                rst_n,
  output sha256_pkg::status_t sts,
  output logic [31:0]         h_out [8]
);
  import sha256_pkg::*;

  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [31:0] s0, s1, wn, t1, t2, wi;

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    rnd_nxt  = rnd_r;
    if (cmd.wr_en) begin
      fill_nxt = fill_r + 6'd1;
    end
    if (cmd.len_inc) begin
      len_nxt = len_r + 61'd1;
    end
    if (cmd.reinit) begin
      len_nxt = '0;
    end
    if (cmd.start) begin
      rnd_nxt = '0;
    end else if (cmd.round) begin
      rnd_nxt = rnd_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  assign wi = w_r[0];
  assign s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn = w_r[0] + s0 + w_r[9] + s1;
  assign t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r] + wi;
  assign t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= cmd.wr_byte;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign sts.fill    = fill_r;
  assign sts.rnd     = rnd_r;
  assign sts.bit_len = {len_r, 3'b000};
  assign h_out       = h_r;
endmodule

// ===== rtl/core/sha256_ctrl.sv =====
// SHA-256 controller: input handshake, padding sequence, rounds and digest output.
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_msg_byte,
  input  logic                in_byte_present,
  input  logic                in_end_of_message,
  input  sha256_pkg::status_t sts,
  input  logic [31:0]         h_in [8],
  output sha256_pkg::cmd_t    cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);
  import sha256_pkg::*;

  state_t      st_r, st_nxt;
  logic        fin_r, fin_nxt;
  logic        pad1_r, pad1_nxt;
  logic        lenok_r, lenok_nxt;
  logic [63:0] blen_r;
  logic [2:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic        take;

  assign in_stall = (st_r != ST_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    st_nxt    = st_r;
    fin_nxt   = fin_r;
    pad1_nxt  = pad1_r;
    lenok_nxt = lenok_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          fin_nxt = in_end_of_message;
          if (in_byte_present) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_byte = in_msg_byte;
            cmd.len_inc = 1'b1;
          end
          if (in_byte_present && sts.fill == 6'd63) begin
            cmd.start = 1'b1;
            pad1_nxt  = in_end_of_message;
            st_nxt    = ST_ROUND;
          end else if (in_end_of_message) begin
            pad1_nxt = 1'b1;
            st_nxt   = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.rnd == 6'd63) begin
          st_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!fin_r) begin
          st_nxt = ST_IDLE;
        end else if (lenok_r) begin
          st_nxt = ST_EMIT;
        end else begin
          if (!pad1_r) begin
            lenok_nxt = 1'b1;
          end
          st_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd.wr_en = 1'b1;
        if (pad1_r) begin
          cmd.wr_byte = PAD_BYTE;
          pad1_nxt    = 1'b0;
          lenok_nxt   = (sts.fill < LEN_POS);
        end else if (lenok_r && sts.fill >= LEN_POS) begin
          cmd.wr_byte = blen_r[{~sts.fill[2:0], 3'b000} +: 8];
        end else begin
          cmd.wr_byte = 8'h00;
        end
        if (sts.fill == 6'd63) begin
          cmd.start = 1'b1;
          st_nxt    = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          if (ov_r && out_last_word) begin
            ov_nxt = 1'b0;
            st_nxt = ST_CLEAR;
          end else begin
            idx_nxt = ov_r ? idx_r + 3'd1 : 3'd0;
            ov_nxt  = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        cmd.reinit = 1'b1;
        fin_nxt    = 1'b0;
        lenok_nxt  = 1'b0;
        st_nxt     = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      fin_r   <= 1'b0;
      pad1_r  <= 1'b0;
      lenok_r <= 1'b0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      fin_r   <= fin_nxt;
      pad1_r  <= pad1_nxt;
      lenok_r <= lenok_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_end_of_message) begin
      blen_r <= sts.bit_len + (in_byte_present ? 64'd8 : 64'd0);
    end
  end

  assign out_valid       = ov_r;
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);
  assign out_digest_word = h_in[idx_r];
endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher.
// Usage:
//   Input channel (in_valid/in_stall) takes one request per cycle while idle:
//   an optional message byte (in_byte_present) and an end-of-message flag.
//   Bytes collect into a 64-byte block; the 64th byte starts compression.
//   Compression runs one round per cycle: 64 rounds, then a fold into the
//   chain words; the input stalls until a full block is compressed.
//   End of message pads with 0x80, zeros and the 64-bit bit length, one byte
//   per cycle, then compresses once or twice.
//   The digest leaves on the output channel as eight requests, word 0 first,
//   out_last_word on word 7; each word holds while out_stall is high.
//   After the last word the chain returns to the initial hash values and
//   the input is taken again.
//   Reset (rst_n low, synchronous) restores the initial hash values and
//   clears the byte count and fill level.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  cmd_t        cmd;
  status_t     sts;
  logic [31:0] h [8];

  sha256_dp u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .rst_n (rst_n),
    .sts   (sts),
    .h_out (h)
  );

  sha256_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_msg_byte       (in_msg_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .sts               (sts),
    .h_in              (h),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );
endmodule

// ===== rtl/core/sha256_checker.sv =====
// Port-level checker for the SHA-256 stream hasher.
module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("stalled output changed");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("word index skipped");
  a_nooverlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest output");
endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
